>>> hdl/tcw_pkg.sv
// Shared constants, command codes, control and status types for the text console writer.
package tcw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TOP_ROWS = 0;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int COPY_END = (ROWS - 1) * COLUMNS;
   localparam bit HAS_COPY = (TOP_ROWS + 1) < ROWS;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TILDE     = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic init_step;
      logic copy_prime;
      logic copy_step;
      logic fill_step;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             need_scroll;
      logic             sweep_end;
      logic             copy_last;
   } sts_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
      return a;
   endfunction

endpackage

>>> hdl/tcw_if.sv
// Valid/ready channel interfaces for the request and response items.
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CMD_W-1:0]     command;
   logic [tcw_pkg::BYTE_W-1:0]    char_code;
   logic [tcw_pkg::BYTE_W-1:0]    attribute;
   logic [tcw_pkg::BYTE_W-1:0]    row;
   logic [tcw_pkg::BYTE_W-1:0]    col;

   modport source (output valid, command, char_code, attribute, row, col, input ready);
   modport sink (input valid, command, char_code, attribute, row, col, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::ROW_W-1:0]     cursor_row_out;
   logic [tcw_pkg::COL_W-1:0]     cursor_col_out;
   logic [tcw_pkg::ADDR_W-1:0]    cursor_linear;
   logic [tcw_pkg::CELL_W-1:0]    cell_data;
   logic                          scrolled;

   modport source (output valid, cursor_row_out, cursor_col_out, cursor_linear, cell_data,
                   scrolled, input ready);
   modport sink (input valid, cursor_row_out, cursor_col_out, cursor_linear, cell_data,
                 scrolled, output ready);
endinterface

>>> hdl/tcw_datapath.sv
// Datapath: screen memory, cursor, sweep counter, item and response registers.
module tcw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::ctl_type              ctl,
   output tcw_pkg::sts_type              sts,
   input  logic [tcw_pkg::CMD_W-1:0]     req_command,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_attribute,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_row,
   input  logic [tcw_pkg::BYTE_W-1:0]    req_col,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row_out,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col_out,
   output logic [tcw_pkg::ADDR_W-1:0]    rsp_cursor_linear,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                          rsp_scrolled
);

   logic [tcw_pkg::CELL_W-1:0]  mem [tcw_pkg::CELLS];

   logic [tcw_pkg::CMD_W-1:0]   cmd_ff;
   logic [tcw_pkg::BYTE_W-1:0]  ch_ff, attr_ff, row_ff, col_ff;
   logic [tcw_pkg::ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [tcw_pkg::ADDR_W-1:0]  sweep_ff, sweep_in;
   logic                        scrolled_ff, scrolled_in;
   logic [tcw_pkg::CELL_W-1:0]  rd_data_ff;

   logic [tcw_pkg::ROW_W-1:0]   crow, row_adv, set_row, rd_row;
   logic [tcw_pkg::COL_W-1:0]   ccol, set_col, rd_col;
   logic                        is_nl, is_bs, is_pr, is_put;
   logic                        last_col, last_row, put_write, need_scroll;
   logic [tcw_pkg::ADDR_W-1:0]  put_addr;
   logic [tcw_pkg::CELL_W-1:0]  put_data, blank;

   logic                        we, re;
   logic [tcw_pkg::ADDR_W-1:0]  waddr, raddr;
   logic [tcw_pkg::CELL_W-1:0]  wdata;

   always_comb begin
      if (cur_row_ff < tcw_pkg::ROW_W'(tcw_pkg::TOP_ROWS)) begin
         crow = tcw_pkg::ROW_W'(tcw_pkg::TOP_ROWS);
      end else if (cur_row_ff > tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
         crow = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      end else begin
         crow = cur_row_ff;
      end
      ccol = (cur_col_ff > tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ?
             tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : cur_col_ff;

      if (row_ff < tcw_pkg::BYTE_W'(tcw_pkg::TOP_ROWS)) begin
         set_row = tcw_pkg::ROW_W'(tcw_pkg::TOP_ROWS);
      end else if (row_ff > tcw_pkg::BYTE_W'(tcw_pkg::ROWS - 1)) begin
         set_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      end else begin
         set_row = row_ff[tcw_pkg::ROW_W-1:0];
      end
      rd_row  = (row_ff > tcw_pkg::BYTE_W'(tcw_pkg::ROWS - 1)) ?
                tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_ff[tcw_pkg::ROW_W-1:0];
      set_col = (col_ff > tcw_pkg::BYTE_W'(tcw_pkg::COLUMNS - 1)) ?
                tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col_ff[tcw_pkg::COL_W-1:0];
      rd_col  = set_col;

      is_put   = cmd_ff == tcw_pkg::CMD_PUT;
      is_nl    = ch_ff == tcw_pkg::CH_NEWLINE;
      is_bs    = ch_ff == tcw_pkg::CH_BACKSPACE;
      is_pr    = (ch_ff >= tcw_pkg::CH_SPACE) && (ch_ff <= tcw_pkg::CH_TILDE);
      last_col = ccol == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
      last_row = crow == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      row_adv  = last_row ? crow : crow + 1'b1;

      put_write   = is_put && (is_pr || (is_bs && (ccol != '0)));
      put_addr    = tcw_pkg::cell_addr(crow, is_bs ? ccol - 1'b1 : ccol);
      blank       = {attr_ff, tcw_pkg::CH_SPACE};
      put_data    = {attr_ff, is_pr ? ch_ff : tcw_pkg::CH_SPACE};
      need_scroll = is_put && (is_nl || (is_pr && last_col)) && last_row;
   end

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (ctl.exec) begin
         unique case (cmd_ff)
            tcw_pkg::CMD_PUT: begin
               cur_row_in = crow;
               cur_col_in = ccol;
               if (is_nl) begin
                  cur_row_in = row_adv;
                  cur_col_in = '0;
               end else if (is_bs) begin
                  if (ccol != '0) begin
                     cur_col_in = ccol - 1'b1;
                  end
               end else if (is_pr) begin
                  if (last_col) begin
                     cur_row_in = row_adv;
                     cur_col_in = '0;
                  end else begin
                     cur_col_in = ccol + 1'b1;
                  end
               end
            end
            tcw_pkg::CMD_SET: begin
               cur_row_in = set_row;
               cur_col_in = set_col;
            end
            tcw_pkg::CMD_CLEAR: begin
               cur_row_in = '0;
               cur_col_in = '0;
            end
            tcw_pkg::CMD_READ: begin
               cur_row_in = cur_row_ff;
               cur_col_in = cur_col_ff;
            end
            default: begin
               cur_row_in = cur_row_ff;
               cur_col_in = cur_col_ff;
            end
         endcase
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = sweep_ff;
      wdata = blank;
      priority if (ctl.init_step) begin
         we    = 1'b1;
         wdata = '0;
      end else if (ctl.copy_step) begin
         we    = 1'b1;
         wdata = rd_data_ff;
      end else if (ctl.fill_step) begin
         we = 1'b1;
      end else if (ctl.exec && put_write) begin
         we    = 1'b1;
         waddr = put_addr;
         wdata = put_data;
      end else begin
         we = 1'b0;
      end

      re    = 1'b0;
      raddr = sweep_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
      priority if (ctl.exec && (cmd_ff == tcw_pkg::CMD_READ)) begin
         re    = 1'b1;
         raddr = tcw_pkg::cell_addr(rd_row, rd_col);
      end else if (ctl.copy_prime) begin
         re = 1'b1;
      end else if (ctl.copy_step && !sts.copy_last) begin
         re    = 1'b1;
         raddr = sweep_ff + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS + 1);
      end else begin
         re = 1'b0;
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (ctl.init_step || ctl.copy_step || ctl.fill_step) begin
         sweep_in = sweep_ff + 1'b1;
      end else if (ctl.exec && (cmd_ff == tcw_pkg::CMD_CLEAR)) begin
         sweep_in = '0;
      end else if (ctl.exec && need_scroll) begin
         sweep_in = tcw_pkg::ADDR_W'(tcw_pkg::TOP_ROWS * tcw_pkg::COLUMNS);
      end

      scrolled_in = scrolled_ff;
      if (ctl.load_item) begin
         scrolled_in = 1'b0;
      end else if (ctl.exec && need_scroll) begin
         scrolled_in = 1'b1;
      end
   end

   assign sts.cmd         = cmd_ff;
   assign sts.need_scroll = need_scroll;
   assign sts.sweep_end   = sweep_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
   assign sts.copy_last   = sweep_ff == tcw_pkg::ADDR_W'(tcw_pkg::COPY_END - 1);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         sweep_ff    <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         sweep_ff    <= sweep_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff  <= req_command;
         ch_ff   <= req_char_code;
         attr_ff <= req_attribute;
         row_ff  <= req_row;
         col_ff  <= req_col;
      end
      if (ctl.finish) begin
         rsp_cursor_row_out <= cur_row_ff;
         rsp_cursor_col_out <= cur_col_ff;
         rsp_cursor_linear  <= tcw_pkg::cell_addr(cur_row_ff, cur_col_ff);
         rsp_cell_data      <= (cmd_ff == tcw_pkg::CMD_READ) ? rd_data_ff : '0;
         rsp_scrolled       <= scrolled_ff;
      end
   end

endmodule

>>> hdl/tcw_ctrl.sv
// Controller state machine: sequences the reset clearing pass, execute, scroll copy, fill and response handoff.
module tcw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  tcw_pkg::sts_type  sts,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcw_pkg::ctl_type  ctl
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_PRIME = 3'd3;
   localparam logic [2:0] S_COPY  = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            ctl.init_step = 1'b1;
            if (sts.sweep_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            if (sts.cmd == tcw_pkg::CMD_CLEAR) begin
               state_in = S_FILL;
            end else if (sts.need_scroll) begin
               state_in = tcw_pkg::HAS_COPY ? S_PRIME : S_FILL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_PRIME: begin
            ctl.copy_prime = 1'b1;
            state_in       = S_COPY;
         end
         S_COPY: begin
            ctl.copy_step = 1'b1;
            if (sts.copy_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            ctl.fill_step = 1'b1;
            if (sts.sweep_end) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  ctl.load_item = 1'b1;
                  state_in      = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter execute");

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while still pending");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid_ff)
      else $error("finished item not presented on the response channel");

   a_copy_exits_to_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |=> ((state_ff == S_COPY) || (state_ff == S_FILL)))
      else $error("scroll copy left without blanking the bottom row");

endmodule

>>> hdl/text_console_writer.sv
// Top level of the text console writer: 80x25 character screen with cursor.
// After reset the block runs a clearing pass over all 2000 cells (one cell per cycle) and
// accepts no item until it ends. An item is executed in the execute state against the
// single-write, single-read screen memory, and its response goes to the output register
// in the final state, during which the next item is accepted. A clear blanks all 2000
// cells; a scroll primes a read, copies 1920 cells up a row and blanks the last row, both
// by the one write port sweeping the screen a cell per cycle. While a response is still
// pending in the output register, the block holds in its final state and takes no item.
module text_console_writer (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);

   tcw_pkg::ctl_type ctl;
   tcw_pkg::sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   tcw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_chan.command),
      .req_char_code      (req_chan.char_code),
      .req_attribute      (req_chan.attribute),
      .req_row            (req_chan.row),
      .req_col            (req_chan.col),
      .rsp_cursor_row_out (rsp_chan.cursor_row_out),
      .rsp_cursor_col_out (rsp_chan.cursor_col_out),
      .rsp_cursor_linear  (rsp_chan.cursor_linear),
      .rsp_cell_data      (rsp_chan.cell_data),
      .rsp_scrolled       (rsp_chan.scrolled)
   );

endmodule

>>> tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: directed table, then random items.
`timescale 1ns / 1ps

module tb_text_console_writer;

   typedef struct packed {
      logic [tcw_pkg::CMD_W-1:0]  command;
      logic [tcw_pkg::BYTE_W-1:0] char_code;
      logic [tcw_pkg::BYTE_W-1:0] attribute;
      logic [tcw_pkg::BYTE_W-1:0] row;
      logic [tcw_pkg::BYTE_W-1:0] col;
   } console_req_type;

   typedef struct packed {
      logic [tcw_pkg::ROW_W-1:0]  row;
      logic [tcw_pkg::COL_W-1:0]  col;
      logic [tcw_pkg::ADDR_W-1:0] linear;
      logic [tcw_pkg::CELL_W-1:0] cell_word;
      logic                       scrolled;
   } console_rsp_type;

   typedef struct {
      console_req_type req;
      bit              typed;
      console_rsp_type rsp;
   } opening_row_type;

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [tcw_pkg::CELL_W-1:0] screen_image [tcw_pkg::CELLS];
   int                         cursor_row_now;
   int                         cursor_col_now;
   console_rsp_type            awaited_rsp [$];
   opening_row_type            opening_rows [25];

   int errors;
   int items_sent;
   int rsp_seen;
   int scrolls_seen;
   int reads_sent;
   int clears_sent;
   int send_calm;
   int take_calm;
   int take_stall;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_text_console_writer: errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned expv,
                                  input int unsigned gotv);
      $display("MISMATCH at %0t, %s: expected %0h, got %0h", $realtime, what, expv, gotv);
      errors++;
   endtask

   function automatic int clamp_to(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void scroll_screen(input logic [tcw_pkg::BYTE_W-1:0] attr);
      for (int r = tcw_pkg::TOP_ROWS; r + 1 < tcw_pkg::ROWS; r++)
         for (int c = 0; c < tcw_pkg::COLUMNS; c++)
            screen_image[r * tcw_pkg::COLUMNS + c] =
               screen_image[(r + 1) * tcw_pkg::COLUMNS + c];
      for (int c = 0; c < tcw_pkg::COLUMNS; c++)
         screen_image[(tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS + c] = {attr, tcw_pkg::CH_SPACE};
      cursor_row_now = tcw_pkg::ROWS - 1;
      cursor_col_now = 0;
   endfunction

   function automatic console_rsp_type advance_console(input console_req_type it);
      console_rsp_type res;
      int              r;
      int              c;
      res = '0;
      unique case (it.command)
         tcw_pkg::CMD_PUT: begin
            cursor_row_now = clamp_to(cursor_row_now, tcw_pkg::TOP_ROWS, tcw_pkg::ROWS - 1);
            cursor_col_now = clamp_to(cursor_col_now, 0, tcw_pkg::COLUMNS - 1);
            if (it.char_code == tcw_pkg::CH_NEWLINE) begin
               cursor_row_now++;
               cursor_col_now = 0;
               if (cursor_row_now >= tcw_pkg::ROWS) begin
                  scroll_screen(it.attribute);
                  res.scrolled = 1'b1;
               end
            end else if (it.char_code == tcw_pkg::CH_BACKSPACE) begin
               if (cursor_col_now > 0) begin
                  cursor_col_now--;
                  screen_image[cursor_row_now * tcw_pkg::COLUMNS + cursor_col_now] =
                     {it.attribute, tcw_pkg::CH_SPACE};
               end
            end else if (it.char_code >= tcw_pkg::CH_SPACE &&
                         it.char_code <= tcw_pkg::CH_TILDE) begin
               screen_image[cursor_row_now * tcw_pkg::COLUMNS + cursor_col_now] =
                  {it.attribute, it.char_code};
               cursor_col_now++;
               if (cursor_col_now >= tcw_pkg::COLUMNS) begin
                  cursor_col_now = 0;
                  cursor_row_now++;
                  if (cursor_row_now >= tcw_pkg::ROWS) begin
                     scroll_screen(it.attribute);
                     res.scrolled = 1'b1;
                  end
               end
            end
         end
         tcw_pkg::CMD_SET: begin
            cursor_row_now = clamp_to(int'(it.row), tcw_pkg::TOP_ROWS, tcw_pkg::ROWS - 1);
            cursor_col_now = clamp_to(int'(it.col), 0, tcw_pkg::COLUMNS - 1);
         end
         tcw_pkg::CMD_CLEAR: begin
            for (int i = 0; i < tcw_pkg::CELLS; i++)
               screen_image[i] = {it.attribute, tcw_pkg::CH_SPACE};
            cursor_row_now = 0;
            cursor_col_now = 0;
         end
         tcw_pkg::CMD_READ: begin
            r = clamp_to(int'(it.row), 0, tcw_pkg::ROWS - 1);
            c = clamp_to(int'(it.col), 0, tcw_pkg::COLUMNS - 1);
            res.cell_word = screen_image[r * tcw_pkg::COLUMNS + c];
         end
      endcase
      res.row    = tcw_pkg::ROW_W'(cursor_row_now);
      res.col    = tcw_pkg::COL_W'(cursor_col_now);
      res.linear = tcw_pkg::ADDR_W'(cursor_row_now * tcw_pkg::COLUMNS + cursor_col_now);
      return res;
   endfunction

   function automatic opening_row_type row_of(input logic [tcw_pkg::CMD_W-1:0] cmd,
                                              input logic [tcw_pkg::BYTE_W-1:0] ch,
                                              input logic [tcw_pkg::BYTE_W-1:0] attr,
                                              input logic [tcw_pkg::BYTE_W-1:0] r,
                                              input logic [tcw_pkg::BYTE_W-1:0] c,
                                              input bit typed, input int er, input int ec,
                                              input int elin, input int ecell,
                                              input bit escr);
      opening_row_type t;
      t.req   = '{command: cmd, char_code: ch, attribute: attr, row: r, col: c};
      t.typed = typed;
      t.rsp   = '{row: tcw_pkg::ROW_W'(er), col: tcw_pkg::COL_W'(ec),
                  linear: tcw_pkg::ADDR_W'(elin), cell_word: tcw_pkg::CELL_W'(ecell),
                  scrolled: escr};
      return t;
   endfunction

   function automatic console_req_type random_request();
      console_req_type it;
      int unsigned     sel;
      int unsigned     pick;
      it.command   = tcw_pkg::CMD_PUT;
      it.char_code = tcw_pkg::BYTE_W'($urandom_range(0, 255));
      it.attribute = tcw_pkg::BYTE_W'($urandom_range(0, 255));
      it.row       = tcw_pkg::BYTE_W'($urandom_range(0, 255));
      it.col       = tcw_pkg::BYTE_W'($urandom_range(0, 255));
      sel  = $urandom_range(0, 999);
      pick = $urandom_range(0, 99);
      if (sel < 10) begin
         it.command = tcw_pkg::CMD_CLEAR;
      end else if (sel < 130) begin
         it.command = tcw_pkg::CMD_SET;
         if (pick < 70) begin
            it.row = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::ROWS - 1));
            it.col = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
         end else if (pick < 85) begin
            it.row = tcw_pkg::BYTE_W'($urandom_range(tcw_pkg::ROWS - 5, tcw_pkg::ROWS - 1));
            it.col = tcw_pkg::BYTE_W'($urandom_range(tcw_pkg::COLUMNS - 10,
                                                      tcw_pkg::COLUMNS - 1));
         end
      end else if (sel < 280) begin
         it.command = tcw_pkg::CMD_READ;
         if (pick < 50) begin
            it.row = tcw_pkg::BYTE_W'(clamp_to(cursor_row_now, 0, tcw_pkg::ROWS - 1));
            it.col = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
         end else if (pick < 85) begin
            it.row = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::ROWS - 1));
            it.col = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
         end
      end else begin
         if (pick < 75)
            it.char_code = tcw_pkg::BYTE_W'($urandom_range(tcw_pkg::CH_SPACE,
                                                           tcw_pkg::CH_TILDE));
         else if (pick < 85)
            it.char_code = tcw_pkg::CH_NEWLINE;
         else if (pick < 92)
            it.char_code = tcw_pkg::CH_BACKSPACE;
         else if ($urandom_range(0, 1))
            it.char_code = tcw_pkg::BYTE_W'($urandom_range(0, tcw_pkg::CH_SPACE - 1));
         else
            it.char_code = tcw_pkg::BYTE_W'($urandom_range(tcw_pkg::CH_TILDE + 1, 255));
      end
      return it;
   endfunction

   task automatic send_item(input console_req_type it, input bit typed,
                            input console_rsp_type typed_rsp);
      int              gap;
      console_rsp_type predicted;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(40, 150);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.command   = it.command;
      req_bus.char_code = it.char_code;
      req_bus.attribute = it.attribute;
      req_bus.row       = it.row;
      req_bus.col       = it.col;
      req_bus.valid     = 1'b1;
      do @(posedge clock); while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
      predicted = advance_console(it);
      awaited_rsp.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      if (it.command == tcw_pkg::CMD_READ) reads_sent++;
      if (it.command == tcw_pkg::CMD_CLEAR) clears_sent++;
   endtask

   task automatic check_response();
      console_rsp_type got;
      console_rsp_type want;
      got = '{row: rsp_bus.cursor_row_out, col: rsp_bus.cursor_col_out,
              linear: rsp_bus.cursor_linear, cell_word: rsp_bus.cell_data,
              scrolled: rsp_bus.scrolled};
      rsp_seen++;
      if (awaited_rsp.size() == 0) begin
         report_mismatch("item with none awaited", 0, 1);
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.scrolled === 1'b1) scrolls_seen++;
      if (got.row !== want.row)
         report_mismatch("cursor row", 32'(want.row), 32'(got.row));
      if (got.col !== want.col)
         report_mismatch("cursor column", 32'(want.col), 32'(got.col));
      if (got.linear !== want.linear)
         report_mismatch("cursor linear", 32'(want.linear), 32'(got.linear));
      if (got.cell_word !== want.cell_word)
         report_mismatch("cell data", 32'(want.cell_word), 32'(got.cell_word));
      if (got.scrolled !== want.scrolled)
         report_mismatch("scrolled", 32'(want.scrolled), 32'(got.scrolled));
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         check_response();
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (take_stall > 0) begin
            rsp_bus.ready = 1'b0;
            take_stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (take_calm > 0)
               take_calm--;
            else if ($urandom_range(0, 99) < 15)
               take_stall = pick_gap();
            else if ($urandom_range(0, 999) < 3)
               take_calm = $urandom_range(200, 600);
         end
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.command   = tcw_pkg::CMD_PUT;
      req_bus.char_code = '0;
      req_bus.attribute = '0;
      req_bus.row       = '0;
      req_bus.col       = '0;
      reset             = 1'b1;
      for (int i = 0; i < tcw_pkg::CELLS; i++) screen_image[i] = '0;
      cursor_row_now = 0;
      cursor_col_now = 0;

      opening_rows[0]  = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd0, 8'd0,
                                1, 0, 0, 0, 16'h0000, 0);
      opening_rows[1]  = row_of(tcw_pkg::CMD_READ, 8'hFF, 8'hFF, 8'd255, 8'd255,
                                1, 0, 0, 0, 16'h0000, 0);
      opening_rows[2]  = row_of(tcw_pkg::CMD_SET, 8'h00, 8'h00, 8'd255, 8'd255,
                                1, 24, 79, 1999, 16'h0000, 0);
      opening_rows[3]  = row_of(tcw_pkg::CMD_PUT, 8'h41, 8'h1E, 8'd0, 8'd0,
                                1, 24, 0, 1920, 16'h0000, 1);
      opening_rows[4]  = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd23, 8'd79,
                                1, 24, 0, 1920, 16'h1E41, 0);
      opening_rows[5]  = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd24, 8'd0,
                                1, 24, 0, 1920, 16'h1E20, 0);
      opening_rows[6]  = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 8'h55, 8'd0, 8'd0,
                                1, 24, 0, 1920, 16'h0000, 0);
      opening_rows[7]  = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_TILDE, 8'hFF, 8'd0, 8'd0,
                                1, 24, 1, 1921, 16'h0000, 0);
      opening_rows[8]  = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_SPACE, 8'h00, 8'd0, 8'd0,
                                0, 0, 0, 0, 16'h0000, 0);
      opening_rows[9]  = row_of(tcw_pkg::CMD_PUT, 8'h1F, 8'h11, 8'd0, 8'd0,
                                0, 0, 0, 0, 16'h0000, 0);
      opening_rows[10] = row_of(tcw_pkg::CMD_PUT, 8'h7F, 8'h22, 8'd0, 8'd0,
                                0, 0, 0, 0, 16'h0000, 0);
      opening_rows[11] = row_of(tcw_pkg::CMD_PUT, 8'h80, 8'h44, 8'd0, 8'd0,
                                0, 0, 0, 0, 16'h0000, 0);
      opening_rows[12] = row_of(tcw_pkg::CMD_PUT, 8'hFF, 8'h66, 8'd0, 8'd0,
                                1, 24, 2, 1922, 16'h0000, 0);
      opening_rows[13] = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 8'h33, 8'd0, 8'd0,
                                1, 24, 1, 1921, 16'h0000, 0);
      opening_rows[14] = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd24, 8'd1,
                                1, 24, 1, 1921, 16'h3320, 0);
      opening_rows[15] = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 8'h07, 8'd0, 8'd0,
                                1, 24, 0, 1920, 16'h0000, 1);
      opening_rows[16] = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd23, 8'd0,
                                1, 24, 0, 1920, 16'hFF7E, 0);
      opening_rows[17] = row_of(tcw_pkg::CMD_SET, 8'h00, 8'h00, 8'd0, 8'd0,
                                1, 0, 0, 0, 16'h0000, 0);
      opening_rows[18] = row_of(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 8'h07, 8'd0, 8'd0,
                                1, 1, 0, 80, 16'h0000, 0);
      opening_rows[19] = row_of(tcw_pkg::CMD_SET, 8'h00, 8'h00, 8'd12, 8'd200,
                                1, 12, 79, 1039, 16'h0000, 0);
      opening_rows[20] = row_of(tcw_pkg::CMD_PUT, 8'h5A, 8'hAB, 8'd0, 8'd0,
                                0, 0, 0, 0, 16'h0000, 0);
      opening_rows[21] = row_of(tcw_pkg::CMD_CLEAR, 8'h00, 8'hFF, 8'd0, 8'd0,
                                1, 0, 0, 0, 16'h0000, 0);
      opening_rows[22] = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd24, 8'd79,
                                1, 0, 0, 0, 16'hFF20, 0);
      opening_rows[23] = row_of(tcw_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'd0, 8'd0,
                                1, 0, 0, 0, 16'h0000, 0);
      opening_rows[24] = row_of(tcw_pkg::CMD_READ, 8'h00, 8'h00, 8'd0, 8'd0,
                                1, 0, 0, 0, 16'h0020, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening_rows[i])
         send_item(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].rsp);
      repeat (1500) send_item(random_request(), 1'b0, '0);
      @(negedge clock);
      req_bus.valid = 1'b0;

      for (int w = 0; w < 200000 && awaited_rsp.size() != 0; w++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (awaited_rsp.size() != 0)
         report_mismatch("items still awaited at the end", 0, awaited_rsp.size());

      $display("Sent %0d items (%0d from the directed table), %0d cell reads, %0d clears.",
               items_sent, $size(opening_rows), reads_sent, clears_sent);
      $display("Checked %0d results, %0d of them with a scroll; %0d mismatches.",
               rsp_seen, scrolls_seen, errors);
      if (errors == 0)
         $display("tb_text_console_writer: clean");
      else
         $display("tb_text_console_writer: errors");
      $finish;
   end

endmodule

>>> sim.f
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
tb/tb_text_console_writer.sv
